// File: design/crcfp_pkg.sv
// Shared types, constants and helper functions of the CRC-checked frame parser.
package crcfp_pkg;

  localparam int unsigned COUNTER_WIDTH_DEF = 32;
  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned LEN_W             = 20;
  localparam int unsigned CRC_W             = 16;
  localparam int unsigned DIGIT_CNT_W       = 3;
  localparam int unsigned NUM_COUNTERS      = 4;

  localparam logic [DIGIT_CNT_W-1:0] MAX_LEN_DIGITS = 3'd6;
  localparam logic [DIGIT_CNT_W-1:0] CRC_DIGITS     = 3'd4;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 20'd1024;

  localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CHAR_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CHAR_0      = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_9      = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_UC_A   = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UC_F   = 8'h46;
  localparam logic [BYTE_W-1:0] CHAR_LC_A   = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LC_F   = 8'h66;

  localparam int unsigned CNT_RESYNC   = 0;
  localparam int unsigned CNT_OVERFLOW = 1;
  localparam int unsigned CNT_GOOD     = 2;
  localparam int unsigned CNT_BAD      = 3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEN,
    PH_CRC,
    PH_PAY
  } phase_e;

  typedef enum logic [1:0] {
    ST_NONE,
    ST_OK,
    ST_CRC_ERR,
    ST_OVERFLOW
  } status_e;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(logic [BYTE_W-1:0] b);
    hex_t h;
    h.valid = 1'b0;
    h.value = b[3:0];
    case (b) inside
      [CHAR_0:CHAR_9]: begin
        h.valid = 1'b1;
      end
      [CHAR_UC_A:CHAR_UC_F], [CHAR_LC_A:CHAR_LC_F]: begin
        h.valid = 1'b1;
        h.value = b[3:0] + 4'd9;
      end
      default: begin
        h.valid = 1'b0;
      end
    endcase
    return h;
  endfunction

  function automatic logic [CRC_W-1:0] crc_byte(logic [CRC_W-1:0] crc_in,
                                                logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: design/crcfp_in_if.sv
// Received-byte stream channel with valid/ready handshake.
interface crcfp_in_if;
  logic                          valid;
  logic                          ready;
  logic [crcfp_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: design/crcfp_out_if.sv
// Parser result channel with valid/ready handshake.
interface crcfp_out_if #(
  parameter int unsigned COUNTER_WIDTH = crcfp_pkg::COUNTER_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic                          payload_valid;
  logic [crcfp_pkg::BYTE_W-1:0]  payload_byte;
  logic [COUNTER_WIDTH-1:0]      resync_count;
  logic [COUNTER_WIDTH-1:0]      overflow_count;
  logic [COUNTER_WIDTH-1:0]      good_frame_count;
  logic [COUNTER_WIDTH-1:0]      bad_crc_count;

  modport source (
    output valid, output status, output payload_valid, output payload_byte,
    output resync_count, output overflow_count, output good_frame_count,
    output bad_crc_count, input ready
  );
  modport sink (
    input valid, input status, input payload_valid, input payload_byte,
    input resync_count, input overflow_count, input good_frame_count,
    input bad_crc_count, output ready
  );
endinterface

// File: design/crc_checked_frame_parser.sv
// Byte-serial parser for '$' len ',' crc ',' payload frames with CRC-16 check.
//
// Usage:
//   rx_i carries one received byte per transaction. Frames have the form
//   '$', 1 to 6 decimal length digits, ',', 4 hex CRC digits, ',', payload.
//   res_o returns exactly one result transaction per accepted byte: status
//   (0 none, 1 ok, 2 crc error, 3 length overflow), the payload byte passed
//   through when payload_valid is set, and four wrapping event counters.
//   cfg_we_i/cfg_wdata_i write max_payload (reset 1024); write only while idle.
// Timing and throughput:
//   A result is registered and appears in the cycle after its byte is accepted.
//   One byte per cycle is sustained while res_o.ready is high; parse state, the
//   8-bit CRC update and decimal accumulate resolve combinationally between registers.
// Reset:
//   Parser returns to idle, running CRC to 0xFFFF, counters to zero,
//   max_payload to 1024. No clearing pass.
// Stall:
//   A result waits in the output register; rx_i.ready drops while it is held
//   and rises in the same cycle res_o.ready takes it.
module crc_checked_frame_parser #(
  parameter int unsigned COUNTER_WIDTH = crcfp_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [crcfp_pkg::LEN_W-1:0]  cfg_wdata_i,
  crcfp_in_if.sink                     rx_i,
  crcfp_out_if.source                  res_o
);

  localparam int unsigned LW = crcfp_pkg::LEN_W;
  localparam int unsigned CW = crcfp_pkg::CRC_W;
  localparam int unsigned DW = crcfp_pkg::DIGIT_CNT_W;
  localparam int unsigned NC = crcfp_pkg::NUM_COUNTERS;

  logic [LW-1:0]            max_payload_q;

  crcfp_pkg::phase_e        phase_q, phase_d;
  logic [LW-1:0]            len_q, len_d;
  logic [DW-1:0]            len_digits_q, len_digits_d;
  logic [CW-1:0]            exp_crc_q, exp_crc_d;
  logic [DW-1:0]            crc_digits_q, crc_digits_d;
  logic [LW-1:0]            seen_q, seen_d;
  logic [CW-1:0]            crc_q, crc_d;
  logic [COUNTER_WIDTH-1:0] cnt_q [NC];

  logic                     out_valid_q;
  crcfp_pkg::status_e       status_q, status_d;
  logic                     pvalid_q, pvalid_d;
  logic [7:0]               pbyte_q, pbyte_d;

  logic                     accept;
  logic [7:0]               b;
  logic                     is_digit, is_dollar, is_comma;
  crcfp_pkg::hex_t          hex;
  logic [LW-1:0]            len_mul;
  logic                     len_over;
  logic [LW-1:0]            seen_inc;
  logic                     frame_done;
  logic [CW-1:0]            crc_next;
  logic [NC-1:0]            ev;
  logic                     clear;

  assign accept     = rx_i.valid && rx_i.ready;
  assign rx_i.ready = !out_valid_q || res_o.ready;

  assign b          = rx_i.rx_byte;
  assign is_digit   = (b >= crcfp_pkg::CHAR_0) && (b <= crcfp_pkg::CHAR_9);
  assign is_dollar  = (b == crcfp_pkg::CHAR_DOLLAR);
  assign is_comma   = (b == crcfp_pkg::CHAR_COMMA);
  assign hex        = crcfp_pkg::hex_decode(b);
  assign len_mul    = {len_q[LW-4:0], 3'b000} + {len_q[LW-2:0], 1'b0} + LW'(b[3:0]);
  assign len_over   = len_q > max_payload_q;
  assign seen_inc   = seen_q + LW'(1);
  assign frame_done = seen_inc >= len_q;
  assign crc_next   = crcfp_pkg::crc_byte(crc_q, b);

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      crcfp_pkg::PH_IDLE: begin
        if (is_dollar) phase_d = crcfp_pkg::PH_LEN;
      end
      crcfp_pkg::PH_LEN: begin
        if (is_digit) begin
          if (len_digits_q >= crcfp_pkg::MAX_LEN_DIGITS) phase_d = crcfp_pkg::PH_IDLE;
        end else if (is_comma && len_digits_q != '0) begin
          phase_d = len_over ? crcfp_pkg::PH_IDLE : crcfp_pkg::PH_CRC;
        end else if (!is_dollar) begin
          phase_d = crcfp_pkg::PH_IDLE;
        end
      end
      crcfp_pkg::PH_CRC: begin
        if (hex.valid) begin
          if (crc_digits_q >= crcfp_pkg::CRC_DIGITS) phase_d = crcfp_pkg::PH_IDLE;
        end else if (is_comma && crc_digits_q == crcfp_pkg::CRC_DIGITS) begin
          phase_d = (len_q == '0) ? crcfp_pkg::PH_IDLE : crcfp_pkg::PH_PAY;
        end else begin
          phase_d = crcfp_pkg::PH_IDLE;
        end
      end
      crcfp_pkg::PH_PAY: begin
        if (frame_done) phase_d = crcfp_pkg::PH_IDLE;
      end
    endcase
  end

  always_comb begin
    len_d        = len_q;
    len_digits_d = len_digits_q;
    exp_crc_d    = exp_crc_q;
    crc_digits_d = crc_digits_q;
    seen_d       = seen_q;
    crc_d        = crc_q;
    status_d     = crcfp_pkg::ST_NONE;
    pvalid_d     = 1'b0;
    pbyte_d      = '0;
    ev           = '0;
    clear        = 1'b0;
    unique case (phase_q)
      crcfp_pkg::PH_IDLE: begin
        clear = is_dollar;
      end
      crcfp_pkg::PH_LEN: begin
        if (is_digit) begin
          if (len_digits_q >= crcfp_pkg::MAX_LEN_DIGITS) begin
            ev[crcfp_pkg::CNT_RESYNC] = 1'b1;
            clear = 1'b1;
          end else begin
            len_d        = len_mul;
            len_digits_d = len_digits_q + DW'(1);
          end
        end else if (is_comma && len_digits_q != '0) begin
          if (len_over) begin
            ev[crcfp_pkg::CNT_OVERFLOW] = 1'b1;
            status_d = crcfp_pkg::ST_OVERFLOW;
            clear    = 1'b1;
          end
        end else if (is_dollar) begin
          ev[crcfp_pkg::CNT_RESYNC] = 1'b1;
          len_d        = '0;
          len_digits_d = '0;
        end else begin
          ev[crcfp_pkg::CNT_RESYNC] = 1'b1;
          clear = 1'b1;
        end
      end
      crcfp_pkg::PH_CRC: begin
        if (hex.valid) begin
          if (crc_digits_q >= crcfp_pkg::CRC_DIGITS) begin
            ev[crcfp_pkg::CNT_RESYNC] = 1'b1;
            clear = 1'b1;
          end else begin
            exp_crc_d    = {exp_crc_q[CW-5:0], hex.value};
            crc_digits_d = crc_digits_q + DW'(1);
          end
        end else if (is_comma && crc_digits_q == crcfp_pkg::CRC_DIGITS) begin
          if (len_q == '0) begin
            clear = 1'b1;
            if (crc_q == exp_crc_q) begin
              ev[crcfp_pkg::CNT_GOOD] = 1'b1;
              status_d = crcfp_pkg::ST_OK;
            end else begin
              ev[crcfp_pkg::CNT_BAD] = 1'b1;
              status_d = crcfp_pkg::ST_CRC_ERR;
            end
          end
        end else begin
          ev[crcfp_pkg::CNT_RESYNC] = 1'b1;
          clear = 1'b1;
        end
      end
      crcfp_pkg::PH_PAY: begin
        pvalid_d = 1'b1;
        pbyte_d  = b;
        crc_d    = crc_next;
        seen_d   = seen_inc;
        if (frame_done) begin
          clear = 1'b1;
          if (crc_next == exp_crc_q) begin
            ev[crcfp_pkg::CNT_GOOD] = 1'b1;
            status_d = crcfp_pkg::ST_OK;
          end else begin
            ev[crcfp_pkg::CNT_BAD] = 1'b1;
            status_d = crcfp_pkg::ST_CRC_ERR;
          end
        end
      end
    endcase
    if (clear) begin
      len_d        = '0;
      len_digits_d = '0;
      exp_crc_d    = '0;
      crc_digits_d = '0;
      seen_d       = '0;
      crc_d        = crcfp_pkg::CRC_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= crcfp_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_we_i) begin
      max_payload_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= crcfp_pkg::PH_IDLE;
      len_q        <= '0;
      len_digits_q <= '0;
      exp_crc_q    <= '0;
      crc_digits_q <= '0;
      seen_q       <= '0;
      crc_q        <= crcfp_pkg::CRC_INIT;
      for (int i = 0; i < NC; i++) cnt_q[i] <= '0;
    end else if (accept) begin
      phase_q      <= phase_d;
      len_q        <= len_d;
      len_digits_q <= len_digits_d;
      exp_crc_q    <= exp_crc_d;
      crc_digits_q <= crc_digits_d;
      seen_q       <= seen_d;
      crc_q        <= crc_d;
      for (int i = 0; i < NC; i++) cnt_q[i] <= cnt_q[i] + COUNTER_WIDTH'(ev[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      pvalid_q <= pvalid_d;
      pbyte_q  <= pbyte_d;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.status           = status_q;
  assign res_o.payload_valid    = pvalid_q;
  assign res_o.payload_byte     = pbyte_q;
  assign res_o.resync_count     = cnt_q[crcfp_pkg::CNT_RESYNC];
  assign res_o.overflow_count   = cnt_q[crcfp_pkg::CNT_OVERFLOW];
  assign res_o.good_frame_count = cnt_q[crcfp_pkg::CNT_GOOD];
  assign res_o.bad_crc_count    = cnt_q[crcfp_pkg::CNT_BAD];

  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> $onehot0(ev))
    else $error("more than one event counter bumped by one byte");

  a_pay_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == crcfp_pkg::PH_PAY |-> len_q != '0)
    else $error("payload phase entered with zero length");

  a_digit_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_digits_q <= crcfp_pkg::MAX_LEN_DIGITS && crc_digits_q <= crcfp_pkg::CRC_DIGITS)
    else $error("digit count out of range");

  a_verdict_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status_d != crcfp_pkg::ST_NONE) |=> phase_q == crcfp_pkg::PH_IDLE)
    else $error("frame verdict did not return parser to idle");

endmodule
